FILE: design/xtea_pkg.sv
// shared types, constants and the round mixing function for the xtea cipher
`default_nettype none

package xtea_pkg;

  localparam logic [31:0] XteaDelta = 32'h9E37_79B9;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RoundCntW = 7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDecrypt = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRounds  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKey0    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKey1    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKey2    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgKey3    = 3'd5;

  localparam logic [RoundCntW-1:0] RoundsReset = 7'd32;

  typedef logic [3:0][WordW-1:0] xtea_key_t;

  // one block in flight plus its running sum
  typedef struct packed {
    logic             vld;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] sum;
  } xtea_lane_t;

  typedef struct packed {
    logic [WordW-1:0] r0;
    logic [WordW-1:0] r1;
  } xtea_pair_t;

  function automatic logic [WordW-1:0] xtea_mix(input logic [WordW-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

`default_nettype wire

FILE: design/xtea_block_cipher.sv
// xtea block cipher, ecb, fully unrolled round pipeline
//
// blocks enter on the in channel (block_first_i, block_second_i) under
// in_valid_i / in_ready_o and leave on the out channel (result_first_o,
// result_second_o) under out_valid_o / out_ready_i. the cfg channel writes
// registers by index: 0 decrypt mode, 1 round count, 2..5 key words 0..3;
// other indexes are dropped. cfg_ready_o is always high. write config only
// while no block is in flight.
// while the receiver keeps up, one block per cycle is taken and delivered.
// a block passes an entry register, one register per half cycle of xtea
// and the output buffer. blocks with fewer rounds ride through the unused
// stages unchanged; counts above MAX_ROUNDS saturate.
// reset empties the pipeline and output buffer and loads decrypt mode 0,
// 32 rounds and an all-zero key.
// when the receiver stalls, the two-entry output buffer keeps taking
// results; once it is full and the last stage holds a block, the whole
// pipeline freezes and in_ready_o drops until a transfer on out frees room.
`default_nettype none

module xtea_block_cipher import xtea_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [WordW-1:0]     block_first_i,
  input  wire logic [WordW-1:0]     block_second_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [WordW-1:0]          result_first_o,
  output logic [WordW-1:0]          result_second_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [WordW-1:0]     cfg_data_i
);

  localparam int unsigned NumStages = 2 * MAX_ROUNDS;
  localparam int unsigned CntW      = $clog2(MAX_ROUNDS + 1);

  logic                 decrypt_q;
  logic [RoundCntW-1:0] rounds_q;
  xtea_key_t            key_q;

  logic [RoundCntW:0]   rounds_wide;
  logic [RoundCntW:0]   rounds_sat;
  logic [CntW-1:0]      rounds_eff;
  logic [WordW-1:0]     sum_init;

  logic                 advance;
  logic                 obuf_full;
  xtea_lane_t           lane [NumStages+1];
  xtea_lane_t           entry_q;
  xtea_pair_t           obuf_in;
  xtea_pair_t           obuf_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
      rounds_q  <= RoundsReset;
      key_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDecrypt: decrypt_q <= cfg_data_i[0];
        CfgRounds:  rounds_q  <= cfg_data_i[RoundCntW-1:0];
        CfgKey0:    key_q[0]  <= cfg_data_i;
        CfgKey1:    key_q[1]  <= cfg_data_i;
        CfgKey2:    key_q[2]  <= cfg_data_i;
        CfgKey3:    key_q[3]  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign rounds_wide = {1'b0, rounds_q};
  assign rounds_sat  = (rounds_wide > (RoundCntW+1)'(MAX_ROUNDS)) ?
                       (RoundCntW+1)'(MAX_ROUNDS) : rounds_wide;
  assign rounds_eff  = rounds_sat[CntW-1:0];

  // decryption runs the sum down from delta times the round count
  assign sum_init = decrypt_q ? (XteaDelta * WordW'(rounds_eff)) : '0;

  // the pipeline only holds when the buffer is full, the receiver stalls
  // and the last stage has a block to hand over
  assign advance    = !obuf_full || out_ready_i || !lane[NumStages].vld;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (advance) begin
      entry_q.vld <= in_valid_i;
      entry_q.v0  <= block_first_i;
      entry_q.v1  <= block_second_i;
      entry_q.sum <= sum_init;
    end
  end

  assign lane[0] = entry_q;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    xtea_round_stage #(
      .Cycle  (s / 2),
      .Second (1'(s % 2)),
      .CntW   (CntW)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .decrypt_i (decrypt_q),
      .rounds_i  (rounds_eff),
      .key_i     (key_q),
      .lane_i    (lane[s]),
      .lane_o    (lane[s+1])
    );
  end

  assign obuf_in.r0 = lane[NumStages].v0;
  assign obuf_in.r1 = lane[NumStages].v1;

  xtea_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && lane[NumStages].vld),
    .push_data_i (obuf_in),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (obuf_out),
    .full_o      (obuf_full)
  );

  assign result_first_o  = obuf_out.r0;
  assign result_second_o = obuf_out.r1;

endmodule

`default_nettype wire

FILE: design/xtea_round_stage.sv
// one half-cycle of xtea as a pipeline register stage
`default_nettype none

module xtea_round_stage import xtea_pkg::*; #(
  parameter int unsigned Cycle  = 0,
  parameter bit          Second = 1'b0,
  parameter int unsigned CntW   = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire logic            decrypt_i,
  input  wire logic [CntW-1:0] rounds_i,
  input  wire xtea_key_t       key_i,
  input  wire xtea_lane_t      lane_i,
  output xtea_lane_t           lane_o
);

  logic             active;
  logic             use_v1;
  logic [WordW-1:0] src;
  logic [WordW-1:0] dst;
  logic [WordW-1:0] key_w;
  logic [WordW-1:0] tweak;
  logic [WordW-1:0] dst_new;
  xtea_lane_t       lane_d;
  xtea_lane_t       lane_q;

  // stages past the block's round count just carry it along
  assign active = (CntW'(Cycle) < rounds_i);

  // encrypt first half and decrypt second half read v1 and update v0
  assign use_v1 = (decrypt_i == Second);

  always_comb begin
    src     = use_v1 ? lane_i.v1 : lane_i.v0;
    dst     = use_v1 ? lane_i.v0 : lane_i.v1;
    key_w   = use_v1 ? key_i[lane_i.sum[1:0]] : key_i[lane_i.sum[12:11]];
    tweak   = xtea_mix(src) ^ (lane_i.sum + key_w);
    dst_new = decrypt_i ? (dst - tweak) : (dst + tweak);
    lane_d  = lane_i;
    if (active) begin
      if (use_v1) begin
        lane_d.v0 = dst_new;
      end else begin
        lane_d.v1 = dst_new;
      end
      if (!Second) begin
        lane_d.sum = decrypt_i ? (lane_i.sum - XteaDelta) : (lane_i.sum + XteaDelta);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (advance_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

FILE: design/xtea_out_buf.sv
// two-entry output buffer that decouples the round pipeline from the receiver
`default_nettype none

module xtea_out_buf import xtea_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire xtea_pair_t push_data_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output xtea_pair_t      out_data_o,
  output logic            full_o
);

  xtea_pair_t ent_q [2];
  xtea_pair_t ent_d [2];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = ent_q[0];

  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      // never full here: the pipeline holds while full and stalled
      if (cnt_q[0]) begin
        ent_d[1] = push_data_i;
      end else begin
        ent_d[0] = push_data_i;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (push_i && pop) begin
      if (cnt_q == 2'd1) begin
        ent_d[0] = push_data_i;
      end else begin
        ent_d[0] = ent_q[1];
        ent_d[1] = push_data_i;
      end
    end else if (pop) begin
      ent_d[0] = ent_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

`default_nettype wire

FILE: design/xtea_checker.sv
// port-level checks for the xtea cipher, bound to the top level
`default_nettype none

module xtea_checker import xtea_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [WordW-1:0]   result_first_o,
  input wire logic [WordW-1:0]   result_second_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o
);

  // a waiting result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_first_o)
      && $stable(result_second_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled receiver
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // while the pipe is frozen, a receiver that keeps stalling keeps the input stalled
  a_stall_spreads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && out_valid_o && !out_ready_i && !in_ready_o |=>
      !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline frozen");

  // config writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

  // no result is valid as reset is released
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (.*);

`default_nettype wire
